FILE: hdl/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest block.
// No dependencies; imported by the front, the core and the top module.
`default_nettype none

package sha1md_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  localparam logic [31:0] HInit [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // One classified message word as it travels from the front to the core.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } core_state_t;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_t;

  function automatic logic [31:0] round_const(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_fn(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sha1md_fifo.sv
// Small first-in first-out queue between the front and the compression core.
// Generic payload width; depends on nothing else.
`default_nettype none

module sha1md_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == COUNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sha1md_front.sv
// Input stage: accepts message words, drops idle ones, forwards the rest.
// Depends on sha1md_pkg (cmd_t).
`default_nettype none

module sha1md_front
  import sha1md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_valid,
  input  wire logic       end_of_message,
  input  wire logic       push,
  output logic            full,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_data
);

  logic hold_valid;
  cmd_t hold;
  logic accept;
  logic drain;

  assign full   = hold_valid & q_full;
  assign accept = push & ~full;
  assign drain  = hold_valid & ~q_full;
  // Drop words that neither carry a byte nor end the message.
  assign q_push = drain & (hold.has_byte | hold.is_end);
  assign q_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.data     <= data_byte;
      hold.has_byte <= byte_valid;
      hold.is_end   <= end_of_message;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sha1md_core.sv
// Back end: byte packing, padding, 80-round compression and digest readout.
// Depends on sha1md_pkg (types, constants, round functions).
`default_nettype none

module sha1md_core
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire cmd_t        q_data,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  core_state_t state;
  core_state_t state_next;
  pad_phase_t  phase;
  pad_phase_t  phase_next;

  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [23:0] acc;
  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  round;
  logic [2:0]  out_idx;

  logic        ins_valid;
  logic [7:0]  ins_byte;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [31:0] w_new;
  logic [31:0] t_sum;
  logic        out_done;

  // Length bytes go out most significant first.
  assign len_sel  = ~fill[2:0];
  assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};
  assign t_sum = {a[26:0], a[31:27]} + round_fn(round, b, c, d) + e
               + round_const(round) + w[0];

  assign out_done = (state == ST_OUT) && pop && (out_idx == WORD_LAST);

  assign empty       = (state != ST_OUT);
  assign digest_word = h[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == WORD_LAST);

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (ins_valid && fill == FILL_LAST) begin
          state_next = ST_ROUND;
        end else if (phase == PH_DONE) begin
          state_next = ST_OUT;
        end
      end
      ST_ROUND: begin
        if (round == ROUND_LAST) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ST_RUN;
      end
      ST_OUT: begin
        if (out_done) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Padding phase: advance through mark, zero fill and length, then wait for readout.
  always_comb begin
    phase_next = phase;
    if (out_done) begin
      phase_next = PH_DATA;
    end else if (state == ST_RUN) begin
      case (phase)
        PH_DATA: begin
          if (q_pop && q_data.is_end) begin
            phase_next = PH_MARK;
          end
        end
        PH_MARK: begin
          phase_next = PH_ZERO;
        end
        PH_ZERO: begin
          if (fill == LEN_POS) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (fill[2:0] == 3'd7) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_comb begin
    q_pop     = 1'b0;
    ins_valid = 1'b0;
    ins_byte  = '0;
    if (state == ST_RUN) begin
      case (phase)
        PH_DATA: begin
          if (!q_empty) begin
            q_pop     = 1'b1;
            ins_valid = q_data.has_byte;
            ins_byte  = q_data.data;
          end
        end
        PH_MARK: begin
          ins_valid = 1'b1;
          ins_byte  = PAD_MARK;
        end
        PH_ZERO: begin
          ins_valid = 1'b1;
          ins_byte  = (fill == LEN_POS) ? len_byte : 8'h00;
        end
        PH_LEN: begin
          ins_valid = 1'b1;
          ins_byte  = len_byte;
        end
        default: begin
          ins_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      phase <= PH_DATA;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Control: fill count, length, round and readout counters, and the chain values.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      bit_len <= '0;
      round   <= '0;
      out_idx <= '0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= HInit[i];
      end
    end else begin
      if (ins_valid) begin
        fill <= fill + 1'b1;
      end
      if (q_pop && q_data.has_byte) begin
        bit_len <= bit_len + 64'd8;
      end
      if (state == ST_ROUND) begin
        round <= round + 1'b1;
      end else begin
        round <= '0;
      end
      if (state == ST_ADD) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (state == ST_OUT && pop) begin
        out_idx <= (out_idx == WORD_LAST) ? '0 : out_idx + 1'b1;
      end
      // Reload the chain and clear the length for the next message.
      if (out_done) begin
        bit_len <= '0;
        for (int i = 0; i < 5; i++) begin
          h[i] <= HInit[i];
        end
      end
    end
  end

  // Datapath: byte packing, schedule window and working variables.
  always_ff @(posedge clk) begin
    if (ins_valid) begin
      acc <= {acc[15:0], ins_byte};
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= {acc, ins_byte};
      end
    end
    if (state == ST_RUN && ins_valid && fill == FILL_LAST) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t_sum;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sha1_message_digest.sv
// SHA-1 digest of a byte stream, one message word (byte, valid, end) per push.
// Throughput: one byte per cycle into the block while the core packs bytes; input
// stalls once the queue fills during the 80 rounds and chain update of each 64-byte block.
// After the ending word: padding bytes at one per cycle between compressions, one or
// two compressions, then five digest words paced by pop.
// Reset (rst, synchronous): queues empty, chain at the initial values, length zero.
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Message side: a word is taken when push is high and full is low.
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  input  wire logic        push,
  output logic             full,
  // Digest side: the oldest word is shown while empty is low; pop takes it.
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             empty,
  input  wire logic        pop
);

  localparam int CmdWidth = $bits(cmd_t);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  cmd_t                q_wr;
  cmd_t                q_rd;
  logic [CmdWidth-1:0] q_rd_bits;

  // Front: register the incoming word and drop idle ones.
  sha1md_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr)
  );

  // Queue: lets the front keep taking words while the core runs its rounds.
  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CmdWidth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_bits),
    .empty   (q_empty)
  );

  assign q_rd = cmd_t'(q_rd_bits);

  // Core: pack bytes, pad, compress, and hold the digest until popped.
  sha1md_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rd),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

`default_nettype wire
